// ===== hdl/ksi_pkg.sv =====
// Shared types, command and status codes for the keyframe scale interpolator.
package ksi_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_EVAL   = 3'd3,
        CMD_SCALE  = 3'd4,
        CMD_READ   = 3'd5,
        CMD_RSV6   = 3'd6,
        CMD_RSV7   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [15:0]        key_time;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic [3:0]         entry_index;
        logic signed [15:0] factor;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [15:0]        out_time;
        logic [4:0]         key_total;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_DIV,
        S_MUL,
        S_LERP,
        S_SCALE,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic search_step;
        logic shift_step;
        logic div_init;
        logic div_step;
        logic mul_step;
        logic lerp_step;
        logic scale_step;
        logic commit;
        logic emit;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic search_done;
        logic shift_done;
        logic div_done;
        logic lane_done;
        logic scale_done;
        logic need_shift;
        logic need_div;
    } t_sts;

endpackage

// ===== hdl/keyframe_scale_interpolator.sv =====
// Top level of the keyframe scale interpolator.
//
// Command port: drive i_item and raise start while busy is low; the item
// is taken at that edge and busy rises on the next cycle.
// Result: one item per command on o_item, marked by o_valid for one cycle.
// The receiver cannot stall; busy falls in the strobe cycle, so the next item
// can be taken at the edge that ends it.
// The time from the accepting edge to the strobe depends on the command and is
// set by the key walk (insert and evaluate), the entry shift loop (insert of a
// new key and remove), the serial divider and multiply steps (evaluate when it
// blends) and the pass over every stored key (scale all).
// Reset leaves one key at time 0 with scale 1.0 on every axis.
module keyframe_scale_interpolator #(
    parameter int MAX_KEYS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ksi_pkg::t_in_item   i_item,
    output logic                o_valid,
    output ksi_pkg::t_out_item  o_item
);

    ksi_pkg::t_ctl ctl;
    ksi_pkg::t_sts sts;

    ksi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    ksi_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// ===== hdl/ksi_ctrl.sv =====
// Command sequencer of the keyframe scale interpolator.
module ksi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_cmd,
    input  ksi_pkg::t_sts   i_sts,
    output ksi_pkg::t_ctl   o_ctl,
    output logic            o_busy
);

    ksi_pkg::t_state r_state, n_state;
    logic [2:0] r_cmd;

    // Hold the state and the command of the item in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ksi_pkg::S_IDLE;
            r_cmd   <= 3'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ksi_pkg::S_IDLE && i_start) begin
                r_cmd <= i_cmd;
            end
        end
    end

    // Advance through the phases of each command
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = (r_state != ksi_pkg::S_IDLE);
        unique case (r_state)
            ksi_pkg::S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state = ksi_pkg::S_SEARCH;
                end
            end
            ksi_pkg::S_SEARCH: begin
                if (i_sts.search_done) begin
                    n_state = ksi_pkg::S_DECIDE;
                end else begin
                    o_ctl.search_step = 1'b1;
                end
            end
            ksi_pkg::S_DECIDE: begin
                if (r_cmd == ksi_pkg::CMD_SCALE) begin
                    n_state = ksi_pkg::S_SCALE;
                end else if (i_sts.need_shift) begin
                    n_state = ksi_pkg::S_SHIFT;
                end else if (i_sts.need_div) begin
                    o_ctl.div_init = 1'b1;
                    n_state = ksi_pkg::S_DIV;
                end else begin
                    o_ctl.commit = 1'b1;
                    n_state = ksi_pkg::S_DONE;
                end
            end
            ksi_pkg::S_SHIFT: begin
                if (i_sts.shift_done) begin
                    o_ctl.commit = 1'b1;
                    n_state = ksi_pkg::S_DONE;
                end else begin
                    o_ctl.shift_step = 1'b1;
                end
            end
            ksi_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ksi_pkg::S_MUL;
                end else begin
                    o_ctl.div_step = 1'b1;
                end
            end
            ksi_pkg::S_MUL: begin
                o_ctl.mul_step = 1'b1;
                n_state = ksi_pkg::S_LERP;
            end
            ksi_pkg::S_LERP: begin
                o_ctl.lerp_step = 1'b1;
                if (i_sts.lane_done) begin
                    n_state = ksi_pkg::S_DONE;
                end else begin
                    n_state = ksi_pkg::S_MUL;
                end
            end
            ksi_pkg::S_SCALE: begin
                if (i_sts.scale_done) begin
                    o_ctl.commit = 1'b1;
                    n_state = ksi_pkg::S_DONE;
                end else begin
                    o_ctl.scale_step = 1'b1;
                end
            end
            ksi_pkg::S_DONE: begin
                o_ctl.emit = 1'b1;
                n_state = ksi_pkg::S_IDLE;
            end
            default: begin
                n_state = ksi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ksi_datapath.sv =====
// Key table, serial divider and multiply unit of the keyframe interpolator.
module ksi_datapath #(
    parameter int MAX_KEYS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ksi_pkg::t_in_item   i_item,
    input  ksi_pkg::t_ctl       i_ctl,
    output ksi_pkg::t_sts       o_sts,
    output logic                o_valid,
    output ksi_pkg::t_out_item  o_item
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [15:0]        r_time [MAX_KEYS];
    logic signed [15:0] r_kx   [MAX_KEYS];
    logic signed [15:0] r_ky   [MAX_KEYS];
    logic signed [15:0] r_kz   [MAX_KEYS];
    logic [CW-1:0]      r_count;

    ksi_pkg::t_in_item  r_in;
    logic [CW-1:0]      r_pos;
    logic [CW-1:0]      r_ptr;
    logic               r_hit;
    logic               r_armed;
    logic [1:0]         r_lane;
    logic [16:0]        r_rem;
    logic [16:0]        r_quo;
    logic [15:0]        r_span;
    logic [4:0]         r_bits;
    logic signed [34:0] r_prod;
    logic signed [15:0] r_res [3];
    logic [15:0]        r_otime;
    logic [1:0]         r_status;
    logic               r_valid;

    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] pos_i, pos_m1_i, ptr_i, idx_i, last_i, clamp_i;
    logic          idx_bad, pos_hit, is_full;
    logic [15:0]   t0, t1, span_raw;
    logic [16:0]   div_trial;

    assign cnt_m1   = r_count - CW'(1);
    assign pos_i    = r_pos[IW-1:0];
    assign pos_m1_i = IW'(r_pos - CW'(1));
    assign ptr_i    = r_ptr[IW-1:0];
    assign last_i   = cnt_m1[IW-1:0];
    assign idx_bad  = (CW'(r_in.entry_index) >= r_count) ||
                      (int'(r_in.entry_index) >= MAX_KEYS);
    assign idx_i    = IW'(r_in.entry_index);
    assign is_full  = (r_count >= CW'(MAX_KEYS));
    assign pos_hit  = (r_pos < r_count) && (r_time[pos_i] == r_in.key_time);
    assign clamp_i  = (r_pos == '0) ? '0 : last_i;
    assign t0       = r_time[pos_m1_i];
    assign t1       = r_time[pos_i];
    assign span_raw = t1 - t0;
    assign div_trial = r_rem - {1'b0, r_span};

    // Status towards the sequencer
    always_comb begin
        o_sts = '0;
        o_sts.search_done = (r_in.cmd != ksi_pkg::CMD_INSERT &&
                             r_in.cmd != ksi_pkg::CMD_EVAL) ||
                            (r_ptr >= r_count) || r_hit;
        o_sts.shift_done = 1'b0;
        if (r_in.cmd == ksi_pkg::CMD_INSERT) begin
            o_sts.shift_done = (r_ptr <= r_pos);
        end else begin
            o_sts.shift_done = (r_ptr + CW'(1) >= r_count);
        end
        o_sts.div_done   = (r_bits == 5'd17);
        o_sts.lane_done  = (r_lane == 2'd2);
        o_sts.scale_done = (r_ptr >= r_count);
        o_sts.need_shift = ((r_in.cmd == ksi_pkg::CMD_INSERT) && !pos_hit && !is_full) ||
                           ((r_in.cmd == ksi_pkg::CMD_REMOVE) && !idx_bad);
        o_sts.need_div   = (r_in.cmd == ksi_pkg::CMD_EVAL) && (r_count != '0) &&
                           (r_pos != '0) && (r_pos != r_count);
    end

    // Lane multiply operands
    logic signed [15:0] a_v, b_v, sc_v;
    logic signed [16:0] diff;
    logic signed [31:0] sc_prod;
    logic signed [23:0] sc_shift;
    logic signed [15:0] sc_sat;

    always_comb begin
        unique case (r_lane)
            2'd0:    begin a_v = r_kx[pos_m1_i]; b_v = r_kx[pos_i]; end
            2'd1:    begin a_v = r_ky[pos_m1_i]; b_v = r_ky[pos_i]; end
            default: begin a_v = r_kz[pos_m1_i]; b_v = r_kz[pos_i]; end
        endcase
        diff = 17'(b_v) - 17'(a_v);
        unique case (r_lane)
            2'd0:    sc_v = r_kx[ptr_i];
            2'd1:    sc_v = r_ky[ptr_i];
            default: sc_v = r_kz[ptr_i];
        endcase
        sc_prod  = 32'(sc_v) * 32'(r_in.factor);
        sc_shift = 24'(sc_prod >>> 8);
        if (sc_shift > 24'sd32767) begin
            sc_sat = 16'sh7fff;
        end else if (sc_shift < -24'sd32768) begin
            sc_sat = -16'sh8000;
        end else begin
            sc_sat = sc_shift[15:0];
        end
    end

    // Table, sequencing registers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CW'(1);
            r_time[0] <= 16'd0;
            r_kx[0]  <= 16'sd256;
            r_ky[0]  <= 16'sd256;
            r_kz[0]  <= 16'sd256;
            r_valid  <= 1'b0;
            r_armed  <= 1'b1;
            for (int k = 1; k < MAX_KEYS; k++) begin
                r_time[k] <= '0;
                r_kx[k] <= '0;
                r_ky[k] <= '0;
                r_kz[k] <= '0;
            end
        end else begin
            r_valid <= i_ctl.emit;
            if (i_ctl.load) begin
                r_in     <= i_item;
                r_ptr    <= '0;
                r_pos    <= '0;
                r_hit    <= 1'b0;
                r_armed  <= 1'b0;
                r_lane   <= '0;
                r_otime  <= '0;
                r_status <= ksi_pkg::ST_OK;
                for (int k = 0; k < 3; k++) r_res[k] <= '0;
            end
            // walk to the first key past the query time, or for insert the first key at or past it
            if (i_ctl.search_step) begin
                if (r_in.cmd == ksi_pkg::CMD_INSERT ?
                        (r_time[ptr_i] < r_in.key_time) :
                        (r_time[ptr_i] <= r_in.key_time)) begin
                    r_ptr <= r_ptr + CW'(1);
                    r_pos <= r_ptr + CW'(1);
                end else begin
                    r_hit <= 1'b1;
                    r_pos <= r_ptr;
                end
            end
            // set up the edit or the lookup once the position is known
            if (o_sts.search_done && !i_ctl.search_step && !r_armed) begin
                r_hit   <= 1'b1;
                r_armed <= 1'b1;
                if (r_in.cmd == ksi_pkg::CMD_INSERT) begin
                    r_ptr <= r_count;
                end else if (r_in.cmd == ksi_pkg::CMD_REMOVE) begin
                    r_ptr <= CW'(r_in.entry_index);
                end else begin
                    r_ptr <= '0;
                end
            end
            // shift one entry per cycle
            if (i_ctl.shift_step) begin
                if (r_in.cmd == ksi_pkg::CMD_INSERT) begin
                    r_time[ptr_i] <= r_time[IW'(r_ptr - CW'(1))];
                    r_kx[ptr_i]   <= r_kx[IW'(r_ptr - CW'(1))];
                    r_ky[ptr_i]   <= r_ky[IW'(r_ptr - CW'(1))];
                    r_kz[ptr_i]   <= r_kz[IW'(r_ptr - CW'(1))];
                    r_ptr <= r_ptr - CW'(1);
                end else begin
                    r_time[ptr_i] <= r_time[IW'(r_ptr + CW'(1))];
                    r_kx[ptr_i]   <= r_kx[IW'(r_ptr + CW'(1))];
                    r_ky[ptr_i]   <= r_ky[IW'(r_ptr + CW'(1))];
                    r_kz[ptr_i]   <= r_kz[IW'(r_ptr + CW'(1))];
                    r_ptr <= r_ptr + CW'(1);
                end
            end
            // restoring divide, one quotient bit per cycle
            if (i_ctl.div_init) begin
                r_span <= (span_raw == 16'd0) ? 16'd1 : span_raw;
                r_rem  <= {1'b0, r_in.key_time - t0};
                r_quo  <= '0;
                r_bits <= '0;
            end
            if (i_ctl.div_step) begin
                if (r_bits == 5'd0) begin
                    // integer part
                    if (r_rem >= {1'b0, r_span}) begin
                        r_rem <= div_trial << 1;
                        r_quo <= 17'd1;
                    end else begin
                        r_rem <= r_rem << 1;
                    end
                end else begin
                    if (r_rem >= {1'b0, r_span}) begin
                        r_rem <= div_trial << 1;
                        r_quo <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_rem <= r_rem << 1;
                        r_quo <= {r_quo[15:0], 1'b0};
                    end
                end
                r_bits <= r_bits + 5'd1;
            end
            if (i_ctl.mul_step) begin
                r_prod <= 35'(diff) * $signed({1'b0, r_quo});
            end
            if (i_ctl.lerp_step) begin
                r_res[r_lane] <= 16'(a_v + 16'(r_prod >>> 16));
                r_lane <= r_lane + 2'd1;
            end
            // scale one component per cycle
            if (i_ctl.scale_step) begin
                unique case (r_lane)
                    2'd0:    r_kx[ptr_i] <= sc_sat;
                    2'd1:    r_ky[ptr_i] <= sc_sat;
                    default: r_kz[ptr_i] <= sc_sat;
                endcase
                if (r_lane == 2'd2) begin
                    r_lane <= '0;
                    r_ptr  <= r_ptr + CW'(1);
                end else begin
                    r_lane <= r_lane + 2'd1;
                end
            end
            // final table update and result fields
            if (i_ctl.commit) begin
                unique case (r_in.cmd)
                    ksi_pkg::CMD_INSERT: begin
                        if (pos_hit || !is_full) begin
                            r_time[pos_i] <= r_in.key_time;
                            r_kx[pos_i] <= r_in.scale_x;
                            r_ky[pos_i] <= r_in.scale_y;
                            r_kz[pos_i] <= r_in.scale_z;
                            if (!pos_hit) r_count <= r_count + CW'(1);
                        end else begin
                            r_status <= ksi_pkg::ST_FULL;
                        end
                    end
                    ksi_pkg::CMD_REMOVE: begin
                        if (idx_bad) r_status <= ksi_pkg::ST_BAD_INDEX;
                        else r_count <= cnt_m1;
                    end
                    ksi_pkg::CMD_CLEAR: r_count <= '0;
                    ksi_pkg::CMD_EVAL: begin
                        if (r_count == '0) begin
                            r_status <= ksi_pkg::ST_EMPTY;
                        end else begin
                            r_res[0] <= r_kx[clamp_i];
                            r_res[1] <= r_ky[clamp_i];
                            r_res[2] <= r_kz[clamp_i];
                        end
                    end
                    ksi_pkg::CMD_READ: begin
                        if (idx_bad) begin
                            r_status <= ksi_pkg::ST_BAD_INDEX;
                        end else begin
                            r_res[0] <= r_kx[idx_i];
                            r_res[1] <= r_ky[idx_i];
                            r_res[2] <= r_kz[idx_i];
                            r_otime  <= r_time[idx_i];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_valid = r_valid;
    always_comb begin
        o_item.out_x     = r_res[0];
        o_item.out_y     = r_res[1];
        o_item.out_z     = r_res[2];
        o_item.out_time  = r_otime;
        o_item.key_total = 5'(r_count);
        o_item.status    = r_status;
    end

endmodule

// ===== sim/keyframe_scale_interpolator_tb.sv =====
// Self-checking testbench for the keyframe scale interpolator.
`timescale 1ns / 1ps

module keyframe_scale_interpolator_tb;

    localparam int NUM_KEYS   = 16;
    localparam int WDOG_LIMIT = 4000;
    localparam int IN_W       = $bits(ksi_pkg::t_in_item);

    // Key table predictor and queue of predicted result items
    class keyframe_board;
        logic [15:0]        times[NUM_KEYS];
        logic signed [15:0] kx[NUM_KEYS];
        logic signed [15:0] ky[NUM_KEYS];
        logic signed [15:0] kz[NUM_KEYS];
        int                 count;
        ksi_pkg::t_out_item pending[$];
        int                 errors;

        function new();
            for (int i = 0; i < NUM_KEYS; i++) begin
                times[i] = '0;
                kx[i] = '0;
                ky[i] = '0;
                kz[i] = '0;
            end
            kx[0] = 16'sd256;
            ky[0] = 16'sd256;
            kz[0] = 16'sd256;
            count = 1;
            errors = 0;
        endfunction

        function automatic longint floor_sh(longint p, int sh);
            return p >>> sh;
        endfunction

        function automatic logic signed [15:0] clip16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function automatic logic signed [15:0] blend_axis(longint a, longint b, longint w);
            longint r;
            r = a + floor_sh((b - a) * w, 16);
            return r[15:0];
        endfunction

        function automatic void move_entry(int dst, int src);
            times[dst] = times[src];
            kx[dst] = kx[src];
            ky[dst] = ky[src];
            kz[dst] = kz[src];
        endfunction

        // Apply one accepted command and queue its predicted result
        function void note_item(ksi_pkg::t_in_item it);
            ksi_pkg::t_out_item r;
            int        pos;
            int        k;
            longint    span;
            longint    w;
            r = '0;
            r.status = ksi_pkg::ST_OK;
            case (ksi_pkg::t_cmd'(it.cmd))
                ksi_pkg::CMD_INSERT: begin
                    pos = 0;
                    while (pos < count && times[pos] < it.key_time) pos++;
                    if (pos < count && times[pos] == it.key_time) begin
                        kx[pos] = it.scale_x;
                        ky[pos] = it.scale_y;
                        kz[pos] = it.scale_z;
                    end else if (count >= NUM_KEYS) begin
                        r.status = ksi_pkg::ST_FULL;
                    end else begin
                        for (int i = count; i > pos; i--) move_entry(i, i - 1);
                        times[pos] = it.key_time;
                        kx[pos] = it.scale_x;
                        ky[pos] = it.scale_y;
                        kz[pos] = it.scale_z;
                        count++;
                    end
                end
                ksi_pkg::CMD_REMOVE: begin
                    if (it.entry_index >= count) begin
                        r.status = ksi_pkg::ST_BAD_INDEX;
                    end else begin
                        for (int i = it.entry_index; i + 1 < count; i++) move_entry(i, i + 1);
                        count--;
                    end
                end
                ksi_pkg::CMD_CLEAR: count = 0;
                ksi_pkg::CMD_EVAL: begin
                    if (count == 0) begin
                        r.status = ksi_pkg::ST_EMPTY;
                    end else begin
                        pos = 0;
                        while (pos < count && times[pos] <= it.key_time) pos++;
                        if (pos == 0 || pos == count) begin
                            k = (pos == 0) ? 0 : count - 1;
                            r.out_x = kx[k];
                            r.out_y = ky[k];
                            r.out_z = kz[k];
                        end else begin
                            span = longint'(times[pos]) - longint'(times[pos - 1]);
                            if (span == 0) span = 1;
                            w = ((longint'(it.key_time) - longint'(times[pos - 1])) << 16)
                                / span;
                            r.out_x = blend_axis(kx[pos - 1], kx[pos], w);
                            r.out_y = blend_axis(ky[pos - 1], ky[pos], w);
                            r.out_z = blend_axis(kz[pos - 1], kz[pos], w);
                        end
                    end
                end
                ksi_pkg::CMD_SCALE: begin
                    for (int i = 0; i < count; i++) begin
                        kx[i] = clip16(floor_sh(longint'(kx[i]) * it.factor, 8));
                        ky[i] = clip16(floor_sh(longint'(ky[i]) * it.factor, 8));
                        kz[i] = clip16(floor_sh(longint'(kz[i]) * it.factor, 8));
                    end
                end
                ksi_pkg::CMD_READ: begin
                    if (it.entry_index >= count) begin
                        r.status = ksi_pkg::ST_BAD_INDEX;
                    end else begin
                        r.out_x = kx[it.entry_index];
                        r.out_y = ky[it.entry_index];
                        r.out_z = kz[it.entry_index];
                        r.out_time = times[it.entry_index];
                    end
                end
                default: ;
            endcase
            r.key_total = count[4:0];
            pending = {pending, r};
        endfunction

        // Compare one result item with the oldest prediction
        function void check_result(ksi_pkg::t_out_item got);
            ksi_pkg::t_out_item exp_r;
            if (pending.size() == 0) begin
                $error("result item with no prediction waiting");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.out_x !== exp_r.out_x) begin
                $error("out_x expected %0d actual %0d", exp_r.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== exp_r.out_y) begin
                $error("out_y expected %0d actual %0d", exp_r.out_y, got.out_y);
                errors++;
            end
            if (got.out_z !== exp_r.out_z) begin
                $error("out_z expected %0d actual %0d", exp_r.out_z, got.out_z);
                errors++;
            end
            if (got.out_time !== exp_r.out_time) begin
                $error("out_time expected %0d actual %0d", exp_r.out_time, got.out_time);
                errors++;
            end
            if (got.key_total !== exp_r.key_total) begin
                $error("key_total expected %0d actual %0d", exp_r.key_total, got.key_total);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status expected %0d actual %0d", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    ksi_pkg::t_in_item  i_item;
    logic               o_valid;
    ksi_pkg::t_out_item o_item;

    keyframe_board board;
    int        idle_cycles;
    bit        allow_gaps;
    bit        timed_out;

    keyframe_scale_interpolator #(.MAX_KEYS(NUM_KEYS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Accept items and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_item(i_item);
                idle_cycles <= 0;
            end else if (o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_valid) board.check_result(o_item);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Send one item, holding start until it is taken
    task automatic send_item(ksi_pkg::t_in_item it);
        int gap;
        gap = 0;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
        end
        // step past the falling edge that dropped start for the last item
        repeat (gap + 1) @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic send_cmd(ksi_pkg::t_cmd c, logic [15:0] t, logic [15:0] sx,
                            logic [15:0] sy, logic [15:0] sz, logic [3:0] idx,
                            logic [15:0] f);
        ksi_pkg::t_in_item it;
        it.cmd = c;
        it.key_time = t;
        it.scale_x = sx;
        it.scale_y = sy;
        it.scale_z = sz;
        it.entry_index = idx;
        it.factor = f;
        send_item(it);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random item, weighted toward keys and evaluation
    task automatic send_random();
        ksi_pkg::t_in_item it;
        int       sel;
        it = ksi_pkg::t_in_item'(IN_W'({$urandom, $urandom, $urandom}));
        it.scale_x = pick_value();
        it.scale_y = pick_value();
        it.scale_z = pick_value();
        sel = $urandom_range(0, 99);
        if (sel < 35) it.cmd = ksi_pkg::CMD_INSERT;
        else if (sel < 45) it.cmd = ksi_pkg::CMD_REMOVE;
        else if (sel < 47) it.cmd = ksi_pkg::CMD_CLEAR;
        else if (sel < 77) it.cmd = ksi_pkg::CMD_EVAL;
        else if (sel < 82) begin
            it.cmd = ksi_pkg::CMD_SCALE;
            it.factor = ($urandom_range(0, 3) == 0) ? pick_value()
                        : 16'(int'($urandom_range(192, 320)));
        end
        else if (sel < 96) it.cmd = ksi_pkg::CMD_READ;
        else it.cmd = ($urandom_range(0, 1) != 0) ? ksi_pkg::CMD_RSV6 : ksi_pkg::CMD_RSV7;
        if (it.cmd inside {ksi_pkg::CMD_REMOVE, ksi_pkg::CMD_READ} &&
                $urandom_range(0, 3) != 0)
            it.entry_index = 4'($urandom_range(0, board.count > 0 ? board.count - 1 : 0));
        send_item(it);
    endtask

    initial begin
        board = new();
        idle_cycles = 0;
        allow_gaps = 1'b0;
        timed_out = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset table, extremes, every command and corner case
        send_cmd(ksi_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_READ, 0, 0, 0, 0, 4'hf, 0);
        send_cmd(ksi_pkg::CMD_EVAL, 16'hffff, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_INSERT, 16'hffff, 16'h7fff, 16'h8000, 16'h0001, 0, 0);
        send_cmd(ksi_pkg::CMD_INSERT, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 0, 0);
        send_cmd(ksi_pkg::CMD_INSERT, 16'h8000, 16'h0100, 16'hff00, 16'h0080, 0, 0);
        send_cmd(ksi_pkg::CMD_EVAL, 16'h4000, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_EVAL, 16'hc000, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_EVAL, 16'hfffe, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_EVAL, 16'h0000, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_SCALE, 0, 0, 0, 0, 0, 16'h7fff);
        send_cmd(ksi_pkg::CMD_SCALE, 0, 0, 0, 0, 0, 16'h8000);
        send_cmd(ksi_pkg::CMD_SCALE, 0, 0, 0, 0, 0, 16'hff80);
        send_cmd(ksi_pkg::CMD_READ, 0, 0, 0, 0, 4'd2, 0);
        send_cmd(ksi_pkg::CMD_REMOVE, 0, 0, 0, 0, 4'd0, 0);
        send_cmd(ksi_pkg::CMD_REMOVE, 0, 0, 0, 0, 4'd9, 0);
        send_cmd(ksi_pkg::CMD_RSV6, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'hf, 16'hffff);
        send_cmd(ksi_pkg::CMD_RSV7, 0, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_EVAL, 16'h1234, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_SCALE, 0, 0, 0, 0, 0, 16'h0200);
        send_cmd(ksi_pkg::CMD_REMOVE, 0, 0, 0, 0, 4'd0, 0);
        // Fill the table past full
        for (int i = 0; i < NUM_KEYS + 1; i++)
            send_cmd(ksi_pkg::CMD_INSERT, 16'(i * 4000 + 7), 16'(i * 300), 16'(-i * 200),
                     16'(i), 0, 0);
        send_cmd(ksi_pkg::CMD_EVAL, 16'd2007, 0, 0, 0, 0, 0);
        send_cmd(ksi_pkg::CMD_REMOVE, 0, 0, 0, 0, 4'd15, 0);

        // Hold off until the table has answered everything
        while (board.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);

        // Random part with gaps, then a final stretch without
        allow_gaps = 1'b1;
        for (int n = 0; n < 850; n++) begin
            if (n == 700) allow_gaps = 1'b0;
            if (n == 400) begin
                while (board.pending.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            send_random();
        end

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
